@@ src/cbs_pkg.sv @@
`default_nettype none

package cbs_pkg;

  // Commands carried by the func field
  typedef enum logic [2:0] {
    FUNC_TICK      = 3'd0,
    FUNC_PREVIEW   = 3'd1,
    FUNC_COUNTDOWN = 3'd2,
    FUNC_TWELVE    = 3'd3,
    FUNC_THREE     = 3'd4,
    FUNC_STOP      = 3'd5
  } func_t;

  // Register indexes
  localparam logic [2:0] REG_BELL_MODE     = 3'd0;
  localparam logic [2:0] REG_COIL_ON_MS    = 3'd1;
  localparam logic [2:0] REG_COIL_OFF_MS   = 3'd2;
  localparam logic [2:0] REG_STRIKE_GAP_MS = 3'd3;
  localparam logic [2:0] REG_GROUP_GAP_MS  = 3'd4;

  // Bell modes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_SINGLE  = 3'd1;
  localparam logic [2:0] MODE_HOURS   = 3'd2;
  localparam logic [2:0] MODE_HALF    = 3'd3;
  localparam logic [2:0] MODE_PAIRS   = 3'd4;
  localparam logic [2:0] MODE_TRIPLES = 3'd5;
  localparam logic [2:0] MODE_SHIPS   = 3'd6;
  localparam logic [2:0] MODE_RSVD    = 3'd7;

  // Register reset values
  localparam logic [15:0] COIL_ON_RESET    = 16'd50;
  localparam logic [15:0] COIL_OFF_RESET   = 16'd100;
  localparam logic [15:0] STRIKE_GAP_RESET = 16'd600;
  localparam logic [15:0] GROUP_GAP_RESET  = 16'd1200;

  localparam logic [10:0] KEY_NONE = 11'h7FF;

  // Fixed sequence lengths
  localparam logic [3:0] COUNTDOWN_STRIKES = 4'd6;
  localparam logic [3:0] TWELVE_STRIKES    = 4'd12;
  localparam logic [3:0] THREE_STRIKES     = 4'd3;
  localparam logic [1:0] GROUP_NONE        = 2'd0;
  localparam logic [1:0] GROUP_PAIR        = 2'd2;
  localparam logic [1:0] GROUP_TRIPLE      = 2'd3;

  typedef struct packed {
    logic [3:0] count;
    logic [1:0] grp;
  } plan_t;

  // hours mod 12, with 0 struck as 12
  function automatic logic [3:0] hour_count(input logic [4:0] h);
    logic [4:0] m;
    m = h;
    if (m >= 5'd24) begin
      m = m - 5'd24;
    end else if (m >= 5'd12) begin
      m = m - 5'd12;
    end
    return (m == 5'd0) ? 4'd12 : m[3:0];
  endfunction

  // 3-2-1 countdown group lengths
  function automatic logic [1:0] countdown_group(input logic [1:0] idx);
    logic [1:0] g;
    unique case (idx)
      2'd0:    g = 2'd3;
      2'd1:    g = 2'd2;
      2'd2:    g = 2'd1;
      default: g = 2'd0;
    endcase
    return g;
  endfunction

  function automatic logic mod3_zero(input logic [3:0] v);
    return (v == 4'd0) || (v == 4'd3) || (v == 4'd6) || (v == 4'd9) ||
           (v == 4'd12) || (v == 4'd15);
  endfunction

endpackage

`default_nettype wire

@@ src/cbs_strike_plan.sv @@
`default_nettype none

// Strike count and grouping for an event at the hour (half=0) or half hour.
module cbs_strike_plan (
  input  wire logic [2:0]    mode,
  input  wire logic [4:0]    hours,
  input  wire logic          half,
  output cbs_pkg::plan_t     plan
);
  import cbs_pkg::*;

  logic [3:0] hc;
  logic [3:0] ships;

  assign hc    = hour_count(hours);
  assign ships = {1'b0, hours[1:0], half};

  always_comb begin
    plan.count = 4'd0;
    plan.grp   = GROUP_NONE;
    unique case (mode)
      MODE_SINGLE: plan.count = half ? 4'd0 : 4'd1;
      MODE_HOURS:  plan.count = half ? 4'd0 : hc;
      MODE_HALF:   plan.count = half ? 4'd1 : hc;
      MODE_PAIRS: begin
        if (!half) begin
          plan.count = hc;
          plan.grp   = GROUP_PAIR;
        end
      end
      MODE_TRIPLES: begin
        if (!half) begin
          plan.count = hc;
          plan.grp   = GROUP_TRIPLE;
        end
      end
      MODE_SHIPS: begin
        plan.count = (ships == 4'd0) ? 4'd8 : ships;
        plan.grp   = GROUP_PAIR;
      end
      default: begin
        plan.count = 4'd0;
        plan.grp   = GROUP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/clock_bell_strike_sequencer_core.sv @@
// Bell strike sequencer for a striking clock.
// Input channel (in_valid/in_stall): one command item per transfer. func 0 is
// the 1 ms tick carrying the clock time; it advances the ms counter, queues the
// automatic strike at :00/:30 and paces strikes. Other commands: preview,
// 3-2-1 countdown, twelve strikes, three grouped strikes, stop.
// Output channel (out_valid/out_stall): exactly one result item per command:
// coil drive level, busy flag and strikes still to go.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write only
// while no item is in flight.
// Timing: the result is registered and shown in the cycle after the item is taken.
// One item per cycle while in_stall is low; the whole update is one pass of
// compare/add logic from the state registers into the state and result registers.
// Stall: the result register holds while out_stall is high; in_stall follows
// out_valid && out_stall, so an item is taken even while a result waits as
// long as that result leaves in the same cycle.
// Reset (rst, sync): sequence idle, coil off, timers zero, no event seen,
// registers at their defaults (mode off, 50/100/600/1200 ms).
`default_nettype none

module clock_bell_strike_sequencer_core #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,

  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data,

  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [2:0] func,
  input  wire logic [4:0] hours,
  input  wire logic [5:0] minutes,
  input  wire logic [5:0] seconds,
  input  wire logic       time_valid,
  input  wire logic       countdown_expired,
  input  wire logic       mute_automatic,
  input  wire logic       suppress_scheduled,

  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       coil_on,
  output      logic       busy_res,
  output      logic [3:0] strikes_left
);
  import cbs_pkg::*;

  // Configuration registers
  logic [2:0]  bell_mode;
  logic [15:0] coil_on_ms;
  logic [15:0] coil_off_ms;
  logic [15:0] strike_gap_ms;
  logic [15:0] group_gap_ms;

  // Sequencer state
  logic [TIME_WIDTH-1:0] now_ms, now_ms_next;
  logic [TIME_WIDTH-1:0] next_strike_ms, next_strike_ms_next;
  logic [TIME_WIDTH-1:0] pulse_start_ms, pulse_start_ms_next;
  logic                  pulse_active, pulse_active_next;
  logic                  sequence_active, sequence_active_next;
  logic [3:0]            remaining_strikes, remaining_strikes_next;
  logic [3:0]            strike_index, strike_index_next;
  logic [1:0]            group_size, group_size_next;
  logic                  pattern_mode, pattern_mode_next;
  logic [1:0]            pattern_index, pattern_index_next;
  logic [1:0]            group_progress, group_progress_next;
  logic [10:0]           last_event_key, last_event_key_next;

  logic       in_accept;
  logic       blocked;
  logic       auto_hit;
  logic       preview_half;
  logic       plan_half;
  logic [10:0] event_key;
  plan_t      plan;

  assign cfg_ready = 1'b1;
  // Take a new item unless the finished result is held by the receiver
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign blocked      = countdown_expired || mute_automatic || suppress_scheduled;
  assign event_key    = 11'(hours) * 11'd60 + 11'(minutes);
  // Preview strikes the latest half hour only in modes that ring it
  assign preview_half = ((bell_mode == MODE_HALF) || (bell_mode == MODE_SHIPS)) &&
                        (minutes >= 6'd30);
  assign plan_half    = (func_t'(func) == FUNC_TICK) ? (minutes == 6'd30) : preview_half;

  assign auto_hit = !blocked && (bell_mode != MODE_OFF) && !sequence_active &&
                    time_valid && ((minutes == 6'd0) || (minutes == 6'd30)) &&
                    (seconds <= 6'd1) && (event_key != last_event_key);

  cbs_strike_plan u_plan (
    .mode  (bell_mode),
    .hours (hours),
    .half  (plan_half),
    .plan  (plan)
  );

  // One pass: command, then strike firing, then end of coil pulse
  always_comb begin
    logic                  do_adv;
    logic                  group_done;
    logic [1:0]            gp_inc;
    logic [15:0]           gap;
    logic [TIME_WIDTH-1:0] pulse_age;

    do_adv     = 1'b0;
    group_done = 1'b0;
    gp_inc     = 2'd0;
    gap        = 16'd0;
    pulse_age  = '0;

    now_ms_next            = now_ms;
    next_strike_ms_next    = next_strike_ms;
    pulse_start_ms_next    = pulse_start_ms;
    pulse_active_next      = pulse_active;
    sequence_active_next   = sequence_active;
    remaining_strikes_next = remaining_strikes;
    strike_index_next      = strike_index;
    group_size_next        = group_size;
    pattern_mode_next      = pattern_mode;
    pattern_index_next     = pattern_index;
    group_progress_next    = group_progress;
    last_event_key_next    = last_event_key;

    unique case (func_t'(func))
      FUNC_TICK: begin
        now_ms_next = now_ms + TIME_WIDTH'(1);
        if (auto_hit) begin
          last_event_key_next = event_key;
          if (plan.count != 4'd0) begin
            sequence_active_next   = 1'b1;
            group_size_next        = plan.grp;
            pattern_mode_next      = 1'b0;
            pattern_index_next     = 2'd0;
            group_progress_next    = 2'd0;
            remaining_strikes_next = plan.count;
            strike_index_next      = 4'd0;
            next_strike_ms_next    = '0;
          end
        end
        do_adv = 1'b1;
      end
      FUNC_PREVIEW: begin
        // stop everything first
        sequence_active_next   = 1'b0;
        remaining_strikes_next = 4'd0;
        strike_index_next      = 4'd0;
        group_size_next        = GROUP_NONE;
        next_strike_ms_next    = '0;
        pattern_mode_next      = 1'b0;
        pattern_index_next     = 2'd0;
        group_progress_next    = 2'd0;
        pulse_active_next      = 1'b0;
        if ((bell_mode != MODE_OFF) && (bell_mode != MODE_RSVD) && time_valid &&
            (plan.count != 4'd0)) begin
          sequence_active_next   = 1'b1;
          group_size_next        = plan.grp;
          remaining_strikes_next = plan.count;
          do_adv                 = 1'b1;
        end
      end
      FUNC_COUNTDOWN: begin
        sequence_active_next   = 1'b1;
        group_size_next        = GROUP_NONE;
        pattern_mode_next      = 1'b1;
        pattern_index_next     = 2'd0;
        group_progress_next    = 2'd0;
        remaining_strikes_next = COUNTDOWN_STRIKES;
        strike_index_next      = 4'd0;
        next_strike_ms_next    = '0;
      end
      FUNC_TWELVE: begin
        sequence_active_next   = 1'b1;
        group_size_next        = GROUP_NONE;
        pattern_mode_next      = 1'b0;
        pattern_index_next     = 2'd0;
        group_progress_next    = 2'd0;
        remaining_strikes_next = TWELVE_STRIKES;
        strike_index_next      = 4'd0;
        next_strike_ms_next    = '0;
      end
      FUNC_THREE: begin
        sequence_active_next   = 1'b1;
        group_size_next        = GROUP_TRIPLE;
        pattern_mode_next      = 1'b0;
        pattern_index_next     = 2'd0;
        group_progress_next    = 2'd0;
        remaining_strikes_next = THREE_STRIKES;
        strike_index_next      = 4'd0;
        next_strike_ms_next    = '0;
      end
      FUNC_STOP: begin
        sequence_active_next   = 1'b0;
        remaining_strikes_next = 4'd0;
        strike_index_next      = 4'd0;
        group_size_next        = GROUP_NONE;
        next_strike_ms_next    = '0;
        pattern_mode_next      = 1'b0;
        pattern_index_next     = 2'd0;
        group_progress_next    = 2'd0;
        pulse_active_next      = 1'b0;
      end
      default: begin
        // unknown command: report state only
      end
    endcase

    // Fire a strike when due; next time 0 means at once
    if (do_adv && sequence_active_next && (remaining_strikes_next != 4'd0) &&
        !pulse_active_next &&
        ((next_strike_ms_next == '0) || (now_ms_next >= next_strike_ms_next))) begin
      pulse_start_ms_next    = now_ms_next;
      pulse_active_next      = 1'b1;
      remaining_strikes_next = remaining_strikes_next - 4'd1;
      strike_index_next      = strike_index_next + 4'd1;
      if (remaining_strikes_next == 4'd0) begin
        sequence_active_next = 1'b0;
      end else begin
        if (pattern_mode_next && (pattern_index_next != 2'd3)) begin
          gp_inc              = group_progress_next + 2'd1;
          group_progress_next = gp_inc;
          if (gp_inc >= countdown_group(pattern_index_next)) begin
            group_progress_next = 2'd0;
            pattern_index_next  = pattern_index_next + 2'd1;
            group_done          = 1'b1;
          end
        end else if (group_size_next == GROUP_PAIR) begin
          group_done = !strike_index_next[0];
        end else if (group_size_next == GROUP_TRIPLE) begin
          group_done = mod3_zero(strike_index_next);
        end
        gap = group_done ? group_gap_ms : strike_gap_ms;
        next_strike_ms_next = now_ms_next + TIME_WIDTH'(coil_on_ms) +
                              TIME_WIDTH'(coil_off_ms) + TIME_WIDTH'(gap);
      end
    end

    // End the coil pulse once it has run coil_on_ms (modular age)
    if (func_t'(func) == FUNC_TICK) begin
      pulse_age = now_ms_next - pulse_start_ms_next;
      if (pulse_active_next && (pulse_age >= TIME_WIDTH'(coil_on_ms))) begin
        pulse_active_next = 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bell_mode     <= MODE_OFF;
      coil_on_ms    <= COIL_ON_RESET;
      coil_off_ms   <= COIL_OFF_RESET;
      strike_gap_ms <= STRIKE_GAP_RESET;
      group_gap_ms  <= GROUP_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BELL_MODE:     bell_mode     <= cfg_data[2:0];
        REG_COIL_ON_MS:    coil_on_ms    <= cfg_data;
        REG_COIL_OFF_MS:   coil_off_ms   <= cfg_data;
        REG_STRIKE_GAP_MS: strike_gap_ms <= cfg_data;
        REG_GROUP_GAP_MS:  group_gap_ms  <= cfg_data;
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms            <= '0;
      next_strike_ms    <= '0;
      pulse_start_ms    <= '0;
      pulse_active      <= 1'b0;
      sequence_active   <= 1'b0;
      remaining_strikes <= 4'd0;
      strike_index      <= 4'd0;
      group_size        <= GROUP_NONE;
      pattern_mode      <= 1'b0;
      pattern_index     <= 2'd0;
      group_progress    <= 2'd0;
      last_event_key    <= KEY_NONE;
    end else if (in_accept) begin
      now_ms            <= now_ms_next;
      next_strike_ms    <= next_strike_ms_next;
      pulse_start_ms    <= pulse_start_ms_next;
      pulse_active      <= pulse_active_next;
      sequence_active   <= sequence_active_next;
      remaining_strikes <= remaining_strikes_next;
      strike_index      <= strike_index_next;
      group_size        <= group_size_next;
      pattern_mode      <= pattern_mode_next;
      pattern_index     <= pattern_index_next;
      group_progress    <= group_progress_next;
      last_event_key    <= last_event_key_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      coil_on      <= pulse_active_next;
      busy_res     <= sequence_active_next || pulse_active_next;
      strikes_left <= remaining_strikes_next;
    end
  end

`ifndef SYNTHESIS
  // an idle sequencer never reports pending strikes
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> (strikes_left == 4'd0))
    else $error("idle result with strikes left");

  // stop clears coil and sequence in its own result
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (func_t'(func) == FUNC_STOP)) |=>
      (out_valid && !coil_on && !busy_res && (strikes_left == 4'd0)))
    else $error("stop did not clear the sequencer");

  // input is held off only by a waiting result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no held result");
`endif

endmodule

`default_nettype wire
